// ===== src/lqs_pkg.sv =====
// Shared constants, codes and control types for the linear queue with search.
`timescale 1ns / 1ps

package lqs_pkg;

    localparam int DEPTH  = 128;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DATA_W = 32;
    localparam int KIND_W = 2;
    localparam int STAT_W = 3;
    localparam int POS_W  = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ    = 2'd0,
        KIND_DEQ    = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        logic capture;
        logic enq_first;
        logic enq_append;
        logic deq_pop;
        logic scan_start;
        logic scan_step;
        logic emit;
        logic take_data;
        logic take_pos;
    } lqs_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  not_empty;
        logic  tail_last;
        logic  match;
        logic  scan_at_tail;
    } lqs_stat_t;

    function automatic logic [POS_W-1:0] to_position(input addr_t offset);
        return POS_W'(offset);
    endfunction

endpackage

// ===== src/lqs_ctrl.sv =====
// Controller state machine for the linear queue with search.
`timescale 1ns / 1ps

module lqs_ctrl
    import lqs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output status_t   status,
    input  lqs_stat_t stat,
    output lqs_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DEQ,
        S_SCAN
    } state_t;

    state_t  state_reg,  state_next;
    logic    done_reg,   done_next;
    status_t status_reg, status_next;

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (stat.kind)
                    KIND_ENQ:
                    begin
                        cmd.emit = 1'b1;
                        if (!stat.not_empty)
                        begin
                            cmd.enq_first = 1'b1;
                            status_next   = ST_OK;
                        end
                        else if (stat.tail_last)
                        begin
                            status_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            cmd.enq_append = 1'b1;
                            status_next    = ST_OK;
                        end
                    end
                    KIND_DEQ:
                    begin
                        if (!stat.not_empty)
                        begin
                            cmd.emit    = 1'b1;
                            status_next = ST_UNDERFLOW;
                        end
                        else
                        begin
                            state_next = S_DEQ;
                        end
                    end
                    KIND_SEARCH:
                    begin
                        if (!stat.not_empty)
                        begin
                            cmd.emit    = 1'b1;
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.emit    = 1'b1;
                        status_next = ST_OK;
                    end
                endcase
            end
            S_DEQ:
            begin
                cmd.deq_pop   = 1'b1;
                cmd.emit      = 1'b1;
                cmd.take_data = 1'b1;
                status_next   = ST_OK;
                state_next    = S_IDLE;
            end
            S_SCAN:
            begin
                if (stat.match)
                begin
                    cmd.emit     = 1'b1;
                    cmd.take_pos = 1'b1;
                    status_next  = ST_OK;
                    state_next   = S_IDLE;
                end
                else if (stat.scan_at_tail)
                begin
                    cmd.emit    = 1'b1;
                    status_next = ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.emit)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

    a_done_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result strobe outside idle");

endmodule

// ===== src/lqs_dpath.sv =====
// Datapath for the linear queue with search: slot memory, pointers, scan and result registers.
`timescale 1ns / 1ps

module lqs_dpath
    import lqs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [KIND_W-1:0]         kind,
    input  logic signed [DATA_W-1:0]  value,
    input  lqs_cmd_t                  cmd,
    output lqs_stat_t                 stat,
    output logic signed [DATA_W-1:0]  data,
    output logic [POS_W-1:0]          position
);

    logic [DATA_W-1:0] mem [DEPTH];

    kind_t             kind_reg;
    logic [DATA_W-1:0] key_reg;
    addr_t             head_reg,  head_next;
    addr_t             tail_reg,  tail_next;
    logic              ne_reg,    ne_next;
    addr_t             scan_reg,  scan_next;
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] data_reg;
    logic [POS_W-1:0]  position_reg;

    addr_t             rd_addr;
    addr_t             wr_addr;
    logic              wr_en;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        ne_next   = ne_reg;
        scan_next = scan_reg;
        wr_en     = cmd.enq_first || cmd.enq_append;
        wr_addr   = cmd.enq_first ? '0 : tail_reg + ADDR_W'(1);
        rd_addr   = cmd.scan_step ? scan_reg + ADDR_W'(1) : head_reg;
        if (cmd.enq_first)
        begin
            head_next = '0;
            tail_next = '0;
            ne_next   = 1'b1;
        end
        else if (cmd.enq_append)
        begin
            tail_next = tail_reg + ADDR_W'(1);
        end
        else if (cmd.deq_pop)
        begin
            if (head_reg == tail_reg)
            begin
                head_next = '0;
                tail_next = '0;
                ne_next   = 1'b0;
            end
            else
            begin
                head_next = head_reg + ADDR_W'(1);
            end
        end
        if (cmd.scan_start)
        begin
            scan_next = head_reg;
        end
        else if (cmd.scan_step)
        begin
            scan_next = scan_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            ne_reg   <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            ne_reg   <= ne_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= key_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        if (cmd.capture)
        begin
            kind_reg <= kind_t'(kind);
            key_reg  <= value;
        end
        if (cmd.emit)
        begin
            data_reg     <= cmd.take_data ? rd_data_reg : '0;
            position_reg <= cmd.take_pos ? to_position(scan_reg - head_reg) : '0;
        end
    end

    assign stat.kind         = kind_reg;
    assign stat.not_empty    = ne_reg;
    assign stat.tail_last    = (tail_reg == ADDR_W'(DEPTH - 1));
    assign stat.match        = (rd_data_reg == key_reg);
    assign stat.scan_at_tail = (scan_reg == tail_reg);

    assign data     = data_reg;
    assign position = position_reg;

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        !ne_reg |-> (head_reg == '0 && tail_reg == '0))
        else $error("pointers not at start on empty queue");

    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        ne_reg |-> head_reg <= tail_reg)
        else $error("head beyond tail");

    a_scan_window: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_start || cmd.scan_step) |=> (scan_reg >= head_reg && scan_reg <= tail_reg))
        else $error("scan outside occupied slots");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.deq_pop |-> ne_reg)
        else $error("pop from empty queue");

endmodule

// ===== src/linear_queue_with_search.sv =====
// Linear queue with search: a request is taken when start is high and busy is low, and each
// request gives one result on status, data and position, marked by done for one cycle; the
// receiver cannot stall it. Enqueue, an empty dequeue or search, and the unused kind keep busy
// high only in the S_EXEC state and give their result in the cycle after it. A dequeue of a
// stored value passes through S_DEQ as well, for the slot memory read. A search reads the
// slot memory through its single read port one entry a cycle from the head, so busy stays
// high while it examines entries up to the first match or the tail, at most DEPTH of them;
// its result appears in the first cycle with busy low. Overflow is reported once the tail
// reaches the last slot, even if slots in front of the head were freed; removing the last
// element returns both pointers to slot 0.
`timescale 1ns / 1ps

module linear_queue_with_search
    import lqs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [KIND_W-1:0]         kind,
    input  logic signed [DATA_W-1:0]  value,
    output logic                      done,
    output logic [STAT_W-1:0]         status,
    output logic signed [DATA_W-1:0]  data,
    output logic [POS_W-1:0]          position
);

    lqs_cmd_t  cmd;
    lqs_stat_t stat;
    status_t   status_code;

    lqs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .status (status_code),
        .stat   (stat),
        .cmd    (cmd)
    );

    lqs_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .kind     (kind),
        .value    (value),
        .cmd      (cmd),
        .stat     (stat),
        .data     (data),
        .position (position)
    );

    assign status = status_code;

endmodule
